### rtl/mm_pkg.sv
// ----------------------------------------------------------------------------
// mm_pkg
// Shared constants, types and helpers of the matrix multiply block.
// ----------------------------------------------------------------------------
package mm_pkg;

  localparam int MAX_DIM = 8;
  localparam int ELEM_W  = 16;
  localparam int ACC_W   = 40;
  localparam int PROD_W  = 2 * ELEM_W;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int PTR_W   = ADDR_W + 1;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int CFG_W   = 4;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    CMD_LOAD_FIRST  = 2'd0,
    CMD_LOAD_SECOND = 2'd1,
    CMD_COMPUTE     = 2'd2
  } mm_op_e;

  typedef enum logic [1:0] {
    REG_NUM_ROWS  = 2'd0,
    REG_INNER_DIM = 2'd1,
    REG_NUM_COLS  = 2'd2
  } mm_reg_e;

  typedef struct packed {
    logic              we_first;
    logic              we_second;
    logic [ADDR_W-1:0] wr_addr_first;
    logic [ADDR_W-1:0] wr_addr_second;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr_first;
    logic [ADDR_W-1:0] rd_addr_second;
    logic              first_k;
    logic              last_k;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic              last_elem;
  } mm_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_busy;
  } mm_stat_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

endpackage

### rtl/mm_ctrl.sv
// ----------------------------------------------------------------------------
// mm_ctrl
// Sequencer: load pointers, dot product walk over rows, columns and inner index.
// ----------------------------------------------------------------------------
module mm_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                cmd_i,
  input  logic [mm_pkg::CFG_W-1:0]  num_rows_i,
  input  logic [mm_pkg::CFG_W-1:0]  inner_dim_i,
  input  logic [mm_pkg::CFG_W-1:0]  num_cols_i,
  input  mm_pkg::mm_stat_t          stat_i,
  output mm_pkg::mm_cmd_t           cmd_o
);
  import mm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT,
    S_ISSUE
  } state_e;

  localparam int PW = IDX_W + DIM_W + 1;

  state_e            state_q;
  logic [PTR_W-1:0]  ptr_first_q;
  logic [PTR_W-1:0]  ptr_second_q;
  logic [IDX_W-1:0]  i_q;
  logic [IDX_W-1:0]  j_q;
  logic [IDX_W-1:0]  k_q;
  logic [DIM_W-1:0]  nr_q;
  logic [DIM_W-1:0]  nk_q;
  logic [DIM_W-1:0]  nc_q;

  logic              accept;
  mm_op_e            op;
  logic              last_i;
  logic              last_j;
  logic              last_k;
  logic [PW-1:0]     addr_a;
  logic [PW-1:0]     addr_b;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign op         = mm_op_e'(cmd_i);

  assign last_i = (DIM_W'(i_q) == nr_q - DIM_W'(1));
  assign last_j = (DIM_W'(j_q) == nc_q - DIM_W'(1));
  assign last_k = (DIM_W'(k_q) == nk_q - DIM_W'(1));

  assign addr_a = PW'(i_q) * PW'(nk_q) + PW'(k_q);
  assign addr_b = PW'(k_q) * PW'(nc_q) + PW'(j_q);

  always_comb begin
    cmd_o                = '0;
    cmd_o.we_first       = accept && (op == CMD_LOAD_FIRST) && !ptr_first_q[ADDR_W];
    cmd_o.we_second      = accept && (op == CMD_LOAD_SECOND) && !ptr_second_q[ADDR_W];
    cmd_o.wr_addr_first  = ptr_first_q[ADDR_W-1:0];
    cmd_o.wr_addr_second = ptr_second_q[ADDR_W-1:0];
    cmd_o.rd_en          = (state_q == S_ISSUE);
    cmd_o.rd_addr_first  = addr_a[ADDR_W-1:0];
    cmd_o.rd_addr_second = addr_b[ADDR_W-1:0];
    cmd_o.first_k        = (k_q == '0);
    cmd_o.last_k         = last_k;
    cmd_o.row            = i_q;
    cmd_o.col            = j_q;
    cmd_o.last_elem      = last_i && last_j;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ptr_first_q  <= '0;
      ptr_second_q <= '0;
      i_q          <= '0;
      j_q          <= '0;
      k_q          <= '0;
      nr_q         <= DIM_W'(1);
      nk_q         <= DIM_W'(1);
      nc_q         <= DIM_W'(1);
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (op)
              CMD_LOAD_FIRST: begin
                if (!ptr_first_q[ADDR_W]) begin
                  ptr_first_q <= ptr_first_q + PTR_W'(1);
                end
              end
              CMD_LOAD_SECOND: begin
                if (!ptr_second_q[ADDR_W]) begin
                  ptr_second_q <= ptr_second_q + PTR_W'(1);
                end
              end
              CMD_COMPUTE: begin
                nr_q         <= clamp_dim(num_rows_i);
                nk_q         <= clamp_dim(inner_dim_i);
                nc_q         <= clamp_dim(num_cols_i);
                i_q          <= '0;
                j_q          <= '0;
                k_q          <= '0;
                ptr_first_q  <= '0;
                ptr_second_q <= '0;
                state_q      <= S_WAIT;
              end
              default: ;
            endcase
          end
        end
        S_WAIT: begin
          if (!stat_i.pipe_busy && !stat_i.out_busy) begin
            state_q <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          if (last_k) begin
            k_q <= '0;
            if (last_j) begin
              j_q <= '0;
              if (last_i) begin
                i_q     <= '0;
                state_q <= S_IDLE;
              end else begin
                i_q     <= i_q + IDX_W'(1);
                state_q <= S_WAIT;
              end
            end else begin
              j_q     <= j_q + IDX_W'(1);
              state_q <= S_WAIT;
            end
          end else begin
            k_q <= k_q + IDX_W'(1);
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // a new dot product starts only with the result register free
  a_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ISSUE && k_q == '0) |-> !stat_i.out_busy)
    else $error("dot product started with result register occupied");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(ptr_first_q) <= DEPTH) && (int'(ptr_second_q) <= DEPTH))
    else $error("load pointer beyond store depth");

  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ISSUE) |-> (DIM_W'(k_q) < nk_q))
    else $error("inner index beyond inner dimension");

endmodule

### rtl/mm_dpath.sv
// ----------------------------------------------------------------------------
// mm_dpath
// Element stores, multiply-accumulate pipeline and result register.
// ----------------------------------------------------------------------------
module mm_dpath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic signed [mm_pkg::ELEM_W-1:0]  element_value_i,
  input  mm_pkg::mm_cmd_t                   cmd_i,
  output mm_pkg::mm_stat_t                  stat_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [mm_pkg::ACC_W-1:0]   product_value_o,
  output logic [mm_pkg::IDX_W-1:0]          row_index_o,
  output logic [mm_pkg::IDX_W-1:0]          col_index_o,
  output logic                              last_o
);
  import mm_pkg::*;

  logic signed [ELEM_W-1:0] mem_first  [DEPTH];
  logic signed [ELEM_W-1:0] mem_second [DEPTH];

  // stage 1: read data
  logic                     v1_q;
  logic signed [ELEM_W-1:0] rd_first_q;
  logic signed [ELEM_W-1:0] rd_second_q;
  logic                     first1_q, last1_q, lastel1_q;
  logic [IDX_W-1:0]         row1_q, col1_q;

  // stage 2: product
  logic                     v2_q;
  logic signed [PROD_W-1:0] mul_q;
  logic                     first2_q, last2_q, lastel2_q;
  logic [IDX_W-1:0]         row2_q, col2_q;

  // stage 3: accumulate
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_base;
  logic signed [ACC_W-1:0]  sum;

  logic                     out_valid_q;
  logic signed [ACC_W-1:0]  out_value_q;
  logic [IDX_W-1:0]         out_row_q, out_col_q;
  logic                     out_last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.we_first) begin
      mem_first[cmd_i.wr_addr_first] <= element_value_i;
    end
    if (cmd_i.we_second) begin
      mem_second[cmd_i.wr_addr_second] <= element_value_i;
    end
    rd_first_q  <= mem_first[cmd_i.rd_addr_first];
    rd_second_q <= mem_second[cmd_i.rd_addr_second];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.rd_en;
      v2_q <= v1_q;
      if (v2_q && last2_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign acc_base = first2_q ? '0 : acc_q;
  assign sum      = acc_base + ACC_W'(mul_q);

  always_ff @(posedge clk_i) begin
    first1_q  <= cmd_i.first_k;
    last1_q   <= cmd_i.last_k;
    lastel1_q <= cmd_i.last_elem;
    row1_q    <= cmd_i.row;
    col1_q    <= cmd_i.col;

    mul_q     <= PROD_W'(rd_first_q) * PROD_W'(rd_second_q);
    first2_q  <= first1_q;
    last2_q   <= last1_q;
    lastel2_q <= lastel1_q;
    row2_q    <= row1_q;
    col2_q    <= col1_q;

    if (v2_q) begin
      acc_q <= sum;
    end
    if (v2_q && last2_q) begin
      out_value_q <= sum;
      out_row_q   <= row2_q;
      out_col_q   <= col2_q;
      out_last_q  <= lastel2_q;
    end
  end

  assign stat_o.pipe_busy = v1_q | v2_q;
  assign stat_o.out_busy  = out_valid_q;

  assign out_valid_o     = out_valid_q;
  assign product_value_o = out_value_q;
  assign row_index_o     = out_row_q;
  assign col_index_o     = out_col_q;
  assign last_o          = out_last_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && last2_q) |-> !out_valid_q)
    else $error("finished dot product would overwrite pending result");

  a_pipe_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |=> v2_q)
    else $error("product stage lost an item");

  a_single_dot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !cmd_i.rd_en) |-> !(cmd_i.rd_en && cmd_i.first_k))
    else $error("dot product issue overlaps drain");

endmodule

### rtl/matrix_multiply.sv
// ----------------------------------------------------------------------------
// matrix_multiply
// Loads two Q8.8 matrices and emits their exact Q24.16 product row-major.
// ----------------------------------------------------------------------------
// Loads: one item per cycle while idle, no result.
// Compute: each result element takes one read of each store per inner step into a
// shared multiply-accumulate, then 3 stages; the next element waits for the
// pipeline to drain and the consumer to take the result. No new item during it.
// Reset: dimensions to 1, load pointers to 0; the stores are not cleared.
// ----------------------------------------------------------------------------
module matrix_multiply (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mm_pkg::PADDR_W-1:0]         paddr,
  input  logic [mm_pkg::PDATA_W-1:0]         pwdata,
  output logic [mm_pkg::PDATA_W-1:0]         prdata,
  output logic                               pready,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         cmd_i,
  input  logic signed [mm_pkg::ELEM_W-1:0]   element_value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [mm_pkg::ACC_W-1:0]    product_value_o,
  output logic [mm_pkg::IDX_W-1:0]           row_index_o,
  output logic [mm_pkg::IDX_W-1:0]           col_index_o,
  output logic                               last_o
);
  import mm_pkg::*;

  logic [CFG_W-1:0] num_rows_q;
  logic [CFG_W-1:0] inner_dim_q;
  logic [CFG_W-1:0] num_cols_q;
  logic             cfg_wr;
  mm_reg_e          reg_sel;
  mm_cmd_t          cmd;
  mm_stat_t         stat;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = mm_reg_e'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q  <= CFG_W'(1);
      inner_dim_q <= CFG_W'(1);
      num_cols_q  <= CFG_W'(1);
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_NUM_ROWS:  num_rows_q  <= pwdata[CFG_W-1:0];
        REG_INNER_DIM: inner_dim_q <= pwdata[CFG_W-1:0];
        REG_NUM_COLS:  num_cols_q  <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_NUM_ROWS:  prdata = PDATA_W'(num_rows_q);
      REG_INNER_DIM: prdata = PDATA_W'(inner_dim_q);
      REG_NUM_COLS:  prdata = PDATA_W'(num_cols_q);
      default:       prdata = '0;
    endcase
  end

  mm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .num_rows_i  (num_rows_q),
    .inner_dim_i (inner_dim_q),
    .num_cols_i  (num_cols_q),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mm_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .element_value_i (element_value_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .product_value_o (product_value_o),
    .row_index_o     (row_index_o),
    .col_index_o     (col_index_o),
    .last_o          (last_o)
  );

endmodule

### bench/matrix_multiply_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix_multiply_tb
// Self-checking bench for the Q8.8 matrix multiply block. Matrices are
// loaded through the item channel, dimensions are set over APB, and every
// emitted product element is compared with a local model of the stores,
// load pointers and exact Q24.16 dot products.
// ----------------------------------------------------------------------------
module matrix_multiply_tb;

  localparam int              ITEMS        = 410;
  localparam int              DRAIN_CYCLES = 24;
  localparam logic [1:0]      CMD_UNUSED   = 2'd3;
  localparam logic [mm_pkg::PADDR_W-1:0] ADDR_UNUSED = 'd12;

  typedef struct packed {
    logic [mm_pkg::ACC_W-1:0] value;
    logic [mm_pkg::IDX_W-1:0] row;
    logic [mm_pkg::IDX_W-1:0] col;
    logic                     last;
  } mm_result_t;

  class mm_scoreboard;
    logic signed [mm_pkg::ELEM_W-1:0] first_mem [mm_pkg::DEPTH];
    logic signed [mm_pkg::ELEM_W-1:0] second_mem [mm_pkg::DEPTH];
    int first_ptr, second_ptr, first_hw, second_hw;
    logic [mm_pkg::CFG_W-1:0] rows_reg, inner_reg, cols_reg;
    mm_result_t product_q [$];
    int fail_count;

    function new();
      first_ptr  = 0;
      second_ptr = 0;
      first_hw   = 0;
      second_hw  = 0;
      rows_reg   = 1;
      inner_reg  = 1;
      cols_reg   = 1;
      fail_count = 0;
    endfunction

    function int dim_of(logic [mm_pkg::CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > mm_pkg::MAX_DIM) return mm_pkg::MAX_DIM;
      return int'(v);
    endfunction

    function void report(string msg);
      if (fail_count < 10) $display("%s", msg);
      fail_count++;
    endfunction

    function int pending();
      return product_q.size();
    endfunction

    function void write_reg(int idx, logic [mm_pkg::PDATA_W-1:0] data);
      case (idx)
        mm_pkg::REG_NUM_ROWS:  rows_reg  = data[mm_pkg::CFG_W-1:0];
        mm_pkg::REG_INNER_DIM: inner_reg = data[mm_pkg::CFG_W-1:0];
        mm_pkg::REG_NUM_COLS:  cols_reg  = data[mm_pkg::CFG_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_input(logic [1:0] cmd, logic [mm_pkg::ELEM_W-1:0] value);
      int nr, nk, nc;
      longint acc;
      mm_result_t r;
      nr = dim_of(rows_reg);
      nk = dim_of(inner_reg);
      nc = dim_of(cols_reg);
      case (cmd)
        mm_pkg::CMD_LOAD_FIRST: begin
          if (first_ptr < mm_pkg::DEPTH) begin
            first_mem[first_ptr] = value;
            first_ptr++;
            if (first_ptr > first_hw) first_hw = first_ptr;
          end
        end
        mm_pkg::CMD_LOAD_SECOND: begin
          if (second_ptr < mm_pkg::DEPTH) begin
            second_mem[second_ptr] = value;
            second_ptr++;
            if (second_ptr > second_hw) second_hw = second_ptr;
          end
        end
        mm_pkg::CMD_COMPUTE: begin
          for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < nc; j++) begin
              acc = 0;
              for (int k = 0; k < nk; k++) begin
                acc += longint'(first_mem[i * nk + k]) * longint'(second_mem[k * nc + j]);
              end
              r.value = acc[mm_pkg::ACC_W-1:0];
              r.row   = i[mm_pkg::IDX_W-1:0];
              r.col   = j[mm_pkg::IDX_W-1:0];
              r.last  = (i == nr - 1) && (j == nc - 1);
              product_q.push_back(r);
            end
          end
          first_ptr  = 0;
          second_ptr = 0;
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [mm_pkg::ACC_W-1:0] value,
                               logic [mm_pkg::IDX_W-1:0] row,
                               logic [mm_pkg::IDX_W-1:0] col, logic last);
      mm_result_t exp_r;
      if (product_q.size() == 0) begin
        report($sformatf("unexpected result: value=%0d row=%0d col=%0d last=%0b",
                         $signed(value), row, col, last));
        return;
      end
      exp_r = product_q.pop_front();
      if (exp_r.value !== value || exp_r.row !== row || exp_r.col !== col ||
          exp_r.last !== last) begin
        report($sformatf("mismatch: exp value=%0d row=%0d col=%0d last=%0b, got value=%0d row=%0d col=%0d last=%0b",
                         $signed(exp_r.value), exp_r.row, exp_r.col, exp_r.last,
                         $signed(value), row, col, last));
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [mm_pkg::PADDR_W-1:0] paddr = '0;
  logic [mm_pkg::PDATA_W-1:0] pwdata = '0;
  logic [mm_pkg::PDATA_W-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] cmd_i = '0;
  logic signed [mm_pkg::ELEM_W-1:0] element_value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [mm_pkg::ACC_W-1:0] product_value_o;
  logic [mm_pkg::IDX_W-1:0] row_index_o;
  logic [mm_pkg::IDX_W-1:0] col_index_o;
  logic last_o;

  mm_scoreboard sb = new();
  int send_idle_pct = 17;
  int recv_idle_pct = 46;
  int item_count = 0;

  matrix_multiply dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cmd_i           (cmd_i),
    .element_value_i (element_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .product_value_o (product_value_o),
    .row_index_o     (row_index_o),
    .col_index_o     (col_index_o),
    .last_o          (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(product_value_o, row_index_o, col_index_o, last_o);
    end
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_item(input logic [1:0] cmd, input logic [mm_pkg::ELEM_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    cmd_i           <= cmd;
    element_value_i <= value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(cmd, value);
    if (cmd != CMD_UNUSED) item_count++;
    if (item_count >= 2 * ITEMS / 3) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end else if (item_count >= ITEMS / 3) begin
      send_idle_pct = 46;
      recv_idle_pct = 17;
    end
  endtask

  // no item in flight and no result owed, then let loads settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // APB write followed by a read-back of the same register
  task automatic configure_reg(input logic [mm_pkg::PADDR_W-1:0] addr,
                               input logic [mm_pkg::CFG_W-1:0] code);
    logic [mm_pkg::PDATA_W-1:0] data;
    logic [31:0]                fill;
    fill = $urandom();
    data = {fill[mm_pkg::PDATA_W-mm_pkg::CFG_W-1:0], code};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.write_reg(int'(addr) / 4, data);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (addr != ADDR_UNUSED && prdata[mm_pkg::CFG_W-1:0] !== code) begin
      sb.report($sformatf("register read-back at %0d: exp %0d got %0d",
                          addr, code, prdata[mm_pkg::CFG_W-1:0]));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [mm_pkg::PADDR_W-1:0] reg_addr(input mm_pkg::mm_reg_e r);
    int a;
    a = 4 * int'(r);
    return a[mm_pkg::PADDR_W-1:0];
  endfunction

  function automatic logic [mm_pkg::CFG_W-1:0] dim_code(input int d);
    logic [31:0] v;
    v = $urandom_range(15, 9);
    if (d == 1 && $urandom_range(9) < 3) return '0;
    if (d == mm_pkg::MAX_DIM && $urandom_range(1) == 1) return v[mm_pkg::CFG_W-1:0];
    return d[mm_pkg::CFG_W-1:0];
  endfunction

  task automatic set_dims(input int nr, input int nk, input int nc);
    logic [31:0] v;
    v = $urandom_range(15);
    configure_reg(reg_addr(mm_pkg::REG_NUM_ROWS), dim_code(nr));
    configure_reg(reg_addr(mm_pkg::REG_INNER_DIM), dim_code(nk));
    configure_reg(reg_addr(mm_pkg::REG_NUM_COLS), dim_code(nc));
    if ($urandom_range(7) == 0) configure_reg(ADDR_UNUSED, v[mm_pkg::CFG_W-1:0]);
  endtask

  function automatic logic [mm_pkg::ELEM_W-1:0] rand_elem();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(19))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return v[mm_pkg::ELEM_W-1:0];
    endcase
  endfunction

  // loads of both matrices interleaved at random, then a compute
  task automatic run_product(input int need_a, input int need_b,
                             input int num_a, input int num_b);
    int left_a, left_b;
    left_a = num_a;
    left_b = num_b;
    while (left_a > 0 || left_b > 0) begin
      if ($urandom_range(19) == 0) send_item(CMD_UNUSED, rand_elem());
      if (left_b == 0 || (left_a > 0 && $urandom_range(1) == 0)) begin
        send_item(mm_pkg::CMD_LOAD_FIRST, rand_elem());
        left_a--;
      end else begin
        send_item(mm_pkg::CMD_LOAD_SECOND, rand_elem());
        left_b--;
      end
    end
    // every entry the compute reads must have been written once
    while (sb.first_hw < need_a) send_item(mm_pkg::CMD_LOAD_FIRST, rand_elem());
    while (sb.second_hw < need_b) send_item(mm_pkg::CMD_LOAD_SECOND, rand_elem());
    if ($urandom_range(9) == 0) wait_idle();
    send_item(mm_pkg::CMD_COMPUTE, rand_elem());
  endtask

  initial begin
    int nr, nk, nc, need_a, need_b;
    bit did_full;
    did_full = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    configure_reg(reg_addr(mm_pkg::REG_NUM_ROWS), 4'd1);
    configure_reg(reg_addr(mm_pkg::REG_INNER_DIM), 4'd1);
    configure_reg(reg_addr(mm_pkg::REG_NUM_COLS), 4'd1);

    // 1x1x1 at the extremes of Q8.8
    send_item(mm_pkg::CMD_LOAD_FIRST, 16'h7fff);
    send_item(mm_pkg::CMD_LOAD_SECOND, 16'h7fff);
    send_item(mm_pkg::CMD_COMPUTE, 16'h0000);
    send_item(mm_pkg::CMD_LOAD_FIRST, 16'h8000);
    send_item(mm_pkg::CMD_LOAD_SECOND, 16'h8000);
    send_item(mm_pkg::CMD_COMPUTE, 16'hffff);
    send_item(mm_pkg::CMD_LOAD_FIRST, 16'h8000);
    send_item(mm_pkg::CMD_LOAD_SECOND, 16'h7fff);
    send_item(mm_pkg::CMD_COMPUTE, 16'h5555);
    send_item(CMD_UNUSED, 16'hffff);
    send_item(mm_pkg::CMD_COMPUTE, 16'haaaa);
    wait_idle();

    // out-of-range codes: rows 15 -> 8, cols 0 -> 1, plus a stray address
    configure_reg(reg_addr(mm_pkg::REG_NUM_ROWS), 4'd15);
    configure_reg(reg_addr(mm_pkg::REG_INNER_DIM), 4'd1);
    configure_reg(reg_addr(mm_pkg::REG_NUM_COLS), 4'd0);
    configure_reg(ADDR_UNUSED, 4'd5);
    send_item(mm_pkg::CMD_LOAD_FIRST, 16'h7fff);
    send_item(mm_pkg::CMD_LOAD_FIRST, 16'h8000);
    send_item(mm_pkg::CMD_LOAD_FIRST, 16'h0000);
    send_item(mm_pkg::CMD_LOAD_FIRST, 16'hffff);
    send_item(mm_pkg::CMD_LOAD_FIRST, 16'h0100);
    send_item(mm_pkg::CMD_LOAD_FIRST, 16'h0001);
    send_item(mm_pkg::CMD_LOAD_FIRST, 16'h8001);
    send_item(mm_pkg::CMD_LOAD_FIRST, 16'h7ffe);
    send_item(mm_pkg::CMD_LOAD_SECOND, 16'h8000);
    send_item(mm_pkg::CMD_COMPUTE, 16'h0000);

    while (item_count < ITEMS) begin
      if (!did_full && item_count >= 150) begin
        // full 8x8x8 with loads past the store depth
        wait_idle();
        set_dims(mm_pkg::MAX_DIM, mm_pkg::MAX_DIM, mm_pkg::MAX_DIM);
        run_product(mm_pkg::DEPTH, mm_pkg::DEPTH, mm_pkg::DEPTH + 3, mm_pkg::DEPTH + 2);
        did_full = 1'b1;
        continue;
      end
      if ($urandom_range(2) == 0 || sb.dim_of(sb.rows_reg) * sb.dim_of(sb.cols_reg) > 16) begin
        if ($urandom_range(4) == 0) begin
          nr = $urandom_range(mm_pkg::MAX_DIM, 1);
          nk = $urandom_range(mm_pkg::MAX_DIM, 1);
          nc = $urandom_range(3, 1);
        end else begin
          nr = $urandom_range(3, 1);
          nk = $urandom_range(3, 1);
          nc = $urandom_range(3, 1);
        end
        wait_idle();
        set_dims(nr, nk, nc);
      end
      need_a = sb.dim_of(sb.rows_reg) * sb.dim_of(sb.inner_reg);
      need_b = sb.dim_of(sb.inner_reg) * sb.dim_of(sb.cols_reg);
      if ($urandom_range(4) == 0) begin
        run_product(need_a, need_b, $urandom_range(need_a + 2), $urandom_range(need_b + 2));
      end else begin
        run_product(need_a, need_b, need_a, need_b);
      end
    end

    wait_idle();
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
